// ----- rtl/lnbs_pkg.sv -----
// lnbs_pkg: shared types, constants and microcode word layout for the lcd nibble bus sequencer
// no dependencies; imported by every module of the block

package lnbs_pkg;

	localparam int STEP_W = 5;

	typedef logic [STEP_W-1:0] step_t;

	// bar geometry
	localparam logic [7:0] BAR_COLUMN     = 8'd19;
	localparam logic [7:0] BAR_FULL_SCALE = 8'd40;
	localparam logic [1:0] LAST_CELL      = 2'd3;

	// value * 32 / full scale as a reciprocal multiply, exact for value below full scale
	localparam int          BAR_SHIFT   = 16;
	localparam int          BAR_RECIP   = (32 * (1 << BAR_SHIFT) + int'(BAR_FULL_SCALE) - 1)
		/ int'(BAR_FULL_SCALE);
	localparam logic [21:0] BAR_RECIP_Q = 22'(BAR_RECIP);

	// expander pin layout
	localparam logic [7:0] PIN_RS    = 8'h01;
	localparam logic [7:0] PIN_EN    = 8'h04;
	localparam logic [7:0] PIN_BL    = 8'h08;

	// lcd byte codes
	localparam logic [7:0] CMD_CLEAR  = 8'h01;
	localparam logic [7:0] CMD_DDRAM  = 8'h80;
	localparam logic [7:0] CHAR_FULL  = 8'hFF;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [11:0] WAIT_EN_HIGH = 12'd1;
	localparam logic [11:0] WAIT_EN_LOW  = 12'd50;
	localparam logic [11:0] WAIT_CLEAR   = 12'd2050;

	typedef enum logic [2:0] {
		ACT_CMD    = 3'd0,
		ACT_DATA   = 3'd1,
		ACT_CURSOR = 3'd2,
		ACT_CLEAR  = 3'd3,
		ACT_BAR    = 3'd4
	} action_t;

	// program entry points
	localparam step_t ADDR_CMD      = 5'd0;
	localparam step_t ADDR_DATA     = 5'd4;
	localparam step_t ADDR_CURSOR   = 5'd8;
	localparam step_t ADDR_CLEAR    = 5'd12;
	localparam step_t ADDR_BAR      = 5'd16;
	localparam step_t ADDR_BAR_LOOP = 5'd17;
	localparam step_t ADDR_MAX      = 5'd24;

	typedef enum logic [2:0] {
		SRC_VALUE      = 3'd0,
		SRC_CURSOR     = 3'd1,
		SRC_CLEAR      = 3'd2,
		SRC_BAR_CURSOR = 3'd3,
		SRC_BAR_CHAR   = 3'd4
	} src_t;

	typedef enum logic [1:0] {
		WSEL_HIGH  = 2'd0,
		WSEL_LOW   = 2'd1,
		WSEL_CLEAR = 2'd2
	} wsel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT = 2'd0,
		SEQ_END  = 2'd1,
		SEQ_LOOP = 2'd2
	} seq_t;

	typedef enum logic {
		OP_NONE  = 1'b0,
		OP_SCALE = 1'b1
	} op_t;

	typedef struct packed {
		logic  emit;
		src_t  src;
		logic  rs;
		logic  lo_nib;
		logic  en;
		wsel_t wsel;
		op_t   op;
		seq_t  seq;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic load;
		logic advance;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic cell_last;
	} dp_stat_t;

	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] b;
		case (row)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h40;
			2'd2:    b = 8'h14;
			default: b = 8'h54;
		endcase
		return b;
	endfunction

endpackage

// ----- rtl/lnbs_ucode_rom.sv -----
// lnbs_ucode_rom: read-only control store, one control word per program step
// depends on lnbs_pkg

module lnbs_ucode_rom (
	input  lnbs_pkg::step_t addr,
	output lnbs_pkg::ctrl_t ctrl
);
	import lnbs_pkg::*;

	function automatic ctrl_t wr(input src_t s, input logic rs, input logic lo, input logic en,
			input wsel_t w, input seq_t q);
		ctrl_t c;
		c.emit   = 1'b1;
		c.src    = s;
		c.rs     = rs;
		c.lo_nib = lo;
		c.en     = en;
		c.wsel   = w;
		c.op     = OP_NONE;
		c.seq    = q;
		c.target = ADDR_BAR_LOOP;
		return c;
	endfunction

	function automatic ctrl_t op_word(input op_t o, input seq_t q);
		ctrl_t c;
		c.emit   = 1'b0;
		c.src    = SRC_VALUE;
		c.rs     = 1'b0;
		c.lo_nib = 1'b0;
		c.en     = 1'b0;
		c.wsel   = WSEL_HIGH;
		c.op     = o;
		c.seq    = q;
		c.target = ADDR_BAR_LOOP;
		return c;
	endfunction

	always_comb begin
		unique case (addr)
			// command byte
			5'd0:  ctrl = wr(SRC_VALUE, 1'b0, 1'b0, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd1:  ctrl = wr(SRC_VALUE, 1'b0, 1'b0, 1'b0, WSEL_LOW, SEQ_NEXT);
			5'd2:  ctrl = wr(SRC_VALUE, 1'b0, 1'b1, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd3:  ctrl = wr(SRC_VALUE, 1'b0, 1'b1, 1'b0, WSEL_LOW, SEQ_END);
			// data character
			5'd4:  ctrl = wr(SRC_VALUE, 1'b1, 1'b0, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd5:  ctrl = wr(SRC_VALUE, 1'b1, 1'b0, 1'b0, WSEL_LOW, SEQ_NEXT);
			5'd6:  ctrl = wr(SRC_VALUE, 1'b1, 1'b1, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd7:  ctrl = wr(SRC_VALUE, 1'b1, 1'b1, 1'b0, WSEL_LOW, SEQ_END);
			// set cursor
			5'd8:  ctrl = wr(SRC_CURSOR, 1'b0, 1'b0, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd9:  ctrl = wr(SRC_CURSOR, 1'b0, 1'b0, 1'b0, WSEL_LOW, SEQ_NEXT);
			5'd10: ctrl = wr(SRC_CURSOR, 1'b0, 1'b1, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd11: ctrl = wr(SRC_CURSOR, 1'b0, 1'b1, 1'b0, WSEL_LOW, SEQ_END);
			// clear, long wait on the final write
			5'd12: ctrl = wr(SRC_CLEAR, 1'b0, 1'b0, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd13: ctrl = wr(SRC_CLEAR, 1'b0, 1'b0, 1'b0, WSEL_LOW, SEQ_NEXT);
			5'd14: ctrl = wr(SRC_CLEAR, 1'b0, 1'b1, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd15: ctrl = wr(SRC_CLEAR, 1'b0, 1'b1, 1'b0, WSEL_CLEAR, SEQ_END);
			// bar: register value * 32 / full scale
			5'd16: ctrl = op_word(OP_SCALE, SEQ_NEXT);
			// bar: per cell, cursor then character, looping over four cells
			5'd17: ctrl = wr(SRC_BAR_CURSOR, 1'b0, 1'b0, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd18: ctrl = wr(SRC_BAR_CURSOR, 1'b0, 1'b0, 1'b0, WSEL_LOW, SEQ_NEXT);
			5'd19: ctrl = wr(SRC_BAR_CURSOR, 1'b0, 1'b1, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd20: ctrl = wr(SRC_BAR_CURSOR, 1'b0, 1'b1, 1'b0, WSEL_LOW, SEQ_NEXT);
			5'd21: ctrl = wr(SRC_BAR_CHAR, 1'b1, 1'b0, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd22: ctrl = wr(SRC_BAR_CHAR, 1'b1, 1'b0, 1'b0, WSEL_LOW, SEQ_NEXT);
			5'd23: ctrl = wr(SRC_BAR_CHAR, 1'b1, 1'b1, 1'b1, WSEL_HIGH, SEQ_NEXT);
			5'd24: ctrl = wr(SRC_BAR_CHAR, 1'b1, 1'b1, 1'b0, WSEL_LOW, SEQ_LOOP);
			default: ctrl = op_word(OP_NONE, SEQ_END);
		endcase
	end

endmodule

// ----- rtl/lnbs_datapath.sv -----
// lnbs_datapath: request operands, bar scaling, pin byte formatting and output register
// depends on lnbs_pkg; driven by the control word of lnbs_ucode_rom

module lnbs_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lnbs_pkg::dp_cmd_t cmd,
	input  lnbs_pkg::ctrl_t   ctrl,
	input  logic [7:0]        value,
	input  logic [7:0]        column,
	input  logic [1:0]        row_index,
	output lnbs_pkg::dp_stat_t stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        port_byte,
	output logic [11:0]       wait_us,
	output logic              last_write
);
	import lnbs_pkg::*;

	logic [7:0]  value_q;
	logic [7:0]  column_q;
	logic [1:0]  row_q;
	logic [5:0]  total_q;
	logic [1:0]  cell_q;
	logic        out_valid_q;
	logic [7:0]  port_q;
	logic [11:0] wait_q;
	logic        last_q;

	logic [29:0] bar_prod;
	logic [2:0]  full;
	logic [2:0]  part;
	logic [2:0]  cell_ext;
	logic [7:0]  cursor_byte;
	logic [7:0]  bar_cursor_byte;
	logic [7:0]  bar_char;
	logic [7:0]  sel_byte;
	logic [7:0]  nib;
	logic [7:0]  pins;
	logic [11:0] wait_sel;
	logic        emit;

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.cell_last = (cell_q == LAST_CELL);
	assign emit           = cmd.advance && ctrl.emit;

	// quotient sits in the bits above the reciprocal shift
	assign bar_prod = 30'(value_q) * 30'(BAR_RECIP_Q);

	assign full     = total_q[5:3];
	assign part     = total_q[2:0];
	assign cell_ext = {1'b0, cell_q};

	assign cursor_byte     = CMD_DDRAM | (row_base(row_q) + column_q);
	// cell 0 sits on the bottom row
	assign bar_cursor_byte = CMD_DDRAM | (row_base(~cell_q) + BAR_COLUMN);

	always_comb begin
		if (cell_ext < full) begin
			bar_char = CHAR_FULL;
		end else if (cell_ext == full && part != 3'd0) begin
			bar_char = {5'd0, part};
		end else begin
			bar_char = CHAR_SPACE;
		end
	end

	always_comb begin
		unique case (ctrl.src)
			SRC_VALUE:      sel_byte = value_q;
			SRC_CURSOR:     sel_byte = cursor_byte;
			SRC_CLEAR:      sel_byte = CMD_CLEAR;
			SRC_BAR_CURSOR: sel_byte = bar_cursor_byte;
			SRC_BAR_CHAR:   sel_byte = bar_char;
			default:        sel_byte = value_q;
		endcase
	end

	always_comb begin
		unique case (ctrl.wsel)
			WSEL_HIGH:  wait_sel = WAIT_EN_HIGH;
			WSEL_LOW:   wait_sel = WAIT_EN_LOW;
			WSEL_CLEAR: wait_sel = WAIT_CLEAR;
			default:    wait_sel = WAIT_EN_LOW;
		endcase
	end

	assign nib  = ctrl.lo_nib ? {sel_byte[3:0], 4'd0} : {sel_byte[7:4], 4'd0};
	assign pins = nib | (ctrl.rs ? PIN_RS : 8'd0) | (ctrl.en ? PIN_EN : 8'd0) | PIN_BL;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q  <= value;
			column_q <= column;
			row_q    <= row_index;
			cell_q   <= 2'd0;
		end else if (cmd.advance) begin
			// value at or above full scale saturates the bar
			if (ctrl.op == OP_SCALE) begin
				total_q <= (value_q >= BAR_FULL_SCALE) ? 6'd32 :
					{1'b0, bar_prod[BAR_SHIFT+4:BAR_SHIFT]};
			end
			if (ctrl.seq == SEQ_LOOP && !stat.cell_last) begin
				cell_q <= cell_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			port_q <= pins;
			wait_q <= wait_sel;
			last_q <= cmd.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign port_byte  = port_q;
	assign wait_us    = wait_q;
	assign last_write = last_q;

endmodule

// ----- rtl/lcd_nibble_bus_sequencer.sv -----
// lcd_nibble_bus_sequencer: request dispatch, step counter and sequencing around the control store
// a taken request loads the step counter, whose first write step then loads the output register;
// the bar runs its scale step before it. throughput: one pin write per cycle unless stalled; the
// next request is taken the cycle after the final write; unknown actions are taken without writes
// reset: arst_n clears the busy flag, step counter and output valid; no clearing pass
// depends on lnbs_pkg, lnbs_ucode_rom, lnbs_datapath

module lcd_nibble_bus_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  value,
	input  logic [7:0]  column,
	input  logic [1:0]  row_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  port_byte,
	output logic [11:0] wait_us,
	output logic        last_write
);
	import lnbs_pkg::*;

	logic     busy_q;
	step_t    step_q;
	ctrl_t    ctrl;
	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     accept;
	logic     known;
	logic     prog_end;
	logic     loop_taken;
	step_t    entry;

	lnbs_ucode_rom u_rom (
		.addr (step_q),
		.ctrl (ctrl)
	);

	always_comb begin
		unique case (action)
			ACT_CMD:    entry = ADDR_CMD;
			ACT_DATA:   entry = ADDR_DATA;
			ACT_CURSOR: entry = ADDR_CURSOR;
			ACT_CLEAR:  entry = ADDR_CLEAR;
			ACT_BAR:    entry = ADDR_BAR;
			default:    entry = ADDR_CMD;
		endcase
	end

	assign in_ready   = !busy_q;
	assign accept     = in_valid && in_ready;
	assign known      = (action <= ACT_BAR);
	assign loop_taken = (ctrl.seq == SEQ_LOOP) && !stat.cell_last;
	assign prog_end   = (ctrl.seq == SEQ_END) || ((ctrl.seq == SEQ_LOOP) && stat.cell_last);

	// a write step holds until the output register can take it
	assign cmd.load    = accept && known;
	assign cmd.advance = busy_q && (!ctrl.emit || stat.out_free);
	assign cmd.last    = prog_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= ADDR_CMD;
		end else if (cmd.load) begin
			busy_q <= 1'b1;
			step_q <= entry;
		end else if (cmd.advance) begin
			if (prog_end) begin
				busy_q <= 1'b0;
			end else if (loop_taken) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_q + 5'd1;
			end
		end
	end

	lnbs_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.ctrl       (ctrl),
		.value      (value),
		.column     (column),
		.row_index  (row_index),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.port_byte  (port_byte),
		.wait_us    (wait_us),
		.last_write (last_write)
	);

`ifndef SYNTHESIS
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= ADDR_MAX)
		else $error("step counter outside program");

	a_stall_holds_step: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && ctrl.emit && !stat.out_free |=> $stable(step_q) && busy_q)
		else $error("step advanced while output was full");

	a_end_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance && prog_end |=> in_ready && out_valid && last_write)
		else $error("program end did not release input with last write");

	a_no_last_midway: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance && ctrl.emit && !prog_end |=> out_valid && !last_write && busy_q)
		else $error("last write flagged before program end");
`endif

endmodule
